@@ rtl/next_session_start_finder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Next session start finder - assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef NEXT_SESSION_START_FINDER_UNIT_MACROS_SVH
`define NEXT_SESSION_START_FINDER_UNIT_MACROS_SVH

// same-cycle implication
`define NSSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nssf_pkg.sv @@
// ----------------------------------------------------------------------------
// nssf_pkg
// Shared types, codes and constants of the next session start finder.
// ----------------------------------------------------------------------------
package nssf_pkg;

  // day number width: floor(48-bit seconds / 86400) plus a few steps forward
  localparam int DW = 34;

  // floor(s / 86400) = floor(floor(s / 128) / 675)
  localparam int DIV_SHIFT = 7;
  localparam int REM_W     = 10;
  localparam int X_W       = REM_W + 2;
  localparam logic [X_W-1:0] DIV_ODD  = 12'd675;
  localparam logic [X_W-1:0] DIV_ODD2 = 12'd1350;
  localparam logic [X_W-1:0] DIV_ODD3 = 12'd2025;
  localparam int DIV_STEPS = 22;
  localparam int U_W       = 2 * DIV_STEPS;
  // bias of 675 * 2^32 keeps the dividend positive
  localparam logic [U_W-1:0] U_BIAS = 44'd2899102924800;
  // day = quotient - 2^32 + 1 (first candidate is the following day)
  localparam logic [DW-1:0] DAY_OFS = 34'h0_FFFF_FFFF;

  localparam int PROD_W = 52;
  localparam logic signed [PROD_W-1:0] DAY_SECONDS = 52'sd86400;
  localparam int OUT_W = 49;

  typedef logic [2:0] wday_t;
  localparam wday_t WD_MON = 3'd0;
  localparam wday_t WD_SAT = 3'd5;
  localparam wday_t WD_SUN = 3'd6;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_PLAIN   = 2'd0;
  localparam mode_t MODE_HOLIDAY = 2'd1;
  localparam mode_t MODE_WRITE   = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOL_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COVERAGE    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_FETCH,
    ST_MATCH,
    ST_MUL,
    ST_SUM,
    ST_FIN
  } walk_state_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] day;
    wday_t                wday;
  } div_res_t;

  // reduce a value below 28 modulo 7
  function automatic wday_t fold7(input logic [4:0] v);
    logic [4:0] r;
    begin
      if (v >= 5'd21) begin
        r = v - 5'd21;
      end else if (v >= 5'd14) begin
        r = v - 5'd14;
      end else if (v >= 5'd7) begin
        r = v - 5'd7;
      end else begin
        r = v;
      end
      return r[2:0];
    end
  endfunction

  function automatic wday_t wday_next(input wday_t w);
    return (w == WD_SUN) ? WD_MON : w + 3'd1;
  endfunction

endpackage

@@ rtl/nssf_ifs.sv @@
// ----------------------------------------------------------------------------
// nssf_req_if / nssf_rsp_if
// Valid/ready channels carrying requests and responses.
// ----------------------------------------------------------------------------
interface nssf_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [47:0] from_time;
  logic [4:0]         entry_index;
  logic signed [31:0] entry_day;

  modport source (output valid, mode, from_time, entry_index, entry_day, input ready);
  modport sink   (input valid, mode, from_time, entry_index, entry_day, output ready);
endinterface

interface nssf_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [48:0] session_start;
  logic               insufficient;

  modport source (output valid, session_start, insufficient, input ready);
  modport sink   (input valid, session_start, insufficient, output ready);
endinterface

@@ rtl/nssf_holtab.sv @@
// ----------------------------------------------------------------------------
// nssf_holtab
// Holiday day table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nssf_holtab #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [31:0]      wdata,
  input  logic                    rd,
  input  logic [AW-1:0]           raddr,
  output logic signed [31:0]      rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/nssf_daydiv.sv @@
// ----------------------------------------------------------------------------
// nssf_daydiv
// Local day number and weekday of the day after a UTC time.
// Radix-4 restoring division by 675 after a shift by 7; weekday kept mod 7
// alongside the quotient digits.
// ----------------------------------------------------------------------------
`include "next_session_start_finder_unit_macros.svh"

module nssf_daydiv (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [47:0]    from_time,
  input  logic signed [17:0]    zone,
  output nssf_pkg::div_res_t    res
);
  import nssf_pkg::*;

  logic signed [48:0]   sum_r;
  logic signed [41:0]   shifted;
  logic [U_W-1:0]       u_val;
  logic [U_W-1:0]       shreg;
  logic [REM_W-1:0]     rem;
  logic [DW-1:0]        quo;
  wday_t                qmod;
  logic [4:0]           cnt;
  logic                 prep;
  logic                 busy;
  logic                 done;

  logic [X_W-1:0]       x;
  logic [1:0]           digit;
  logic [X_W-1:0]       x_rem;

  assign shifted = sum_r[48:DIV_SHIFT];
  assign u_val   = U_W'(shifted) + U_BIAS;

  always_comb begin
    x = {rem, shreg[U_W-1:U_W-2]};
    priority if (x >= DIV_ODD3) begin
      digit = 2'd3;
      x_rem = x - DIV_ODD3;
    end else if (x >= DIV_ODD2) begin
      digit = 2'd2;
      x_rem = x - DIV_ODD2;
    end else if (x >= DIV_ODD) begin
      digit = 2'd1;
      x_rem = x - DIV_ODD;
    end else begin
      digit = 2'd0;
      x_rem = x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep <= 1'b0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prep <= 1'b1;
      end else if (prep) begin
        prep <= 1'b0;
        busy <= 1'b1;
      end else if (busy && cnt == 5'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= 49'(from_time) + 49'(zone);
    end
    if (prep) begin
      shreg <= u_val;
      rem   <= '0;
      quo   <= '0;
      qmod  <= WD_MON;
      cnt   <= '0;
    end else if (busy) begin
      shreg <= {shreg[U_W-3:0], 2'b00};
      rem   <= x_rem[REM_W-1:0];
      quo   <= {quo[DW-3:0], digit};
      qmod  <= fold7({qmod, 2'b00} + 5'(digit));
      cnt   <= cnt + 5'd1;
    end
  end

  // weekday of quotient - 2^32 + 1 equals quotient mod 7
  always_comb begin
    res.done = done;
    res.day  = signed'(quo - DAY_OFS);
    res.wday = qmod;
  end

  `NSSF_ASSERT_NOW(a_rem_bound, busy, {2'b00, rem} < DIV_ODD, "remainder out of range")
  `NSSF_ASSERT_NOW(a_start_idle, start, !busy && !prep, "divider restarted while busy")

endmodule

@@ rtl/next_session_start_finder_unit.sv @@
// ----------------------------------------------------------------------------
// next_session_start_finder_unit
// A query passes from acceptance through the day divider, then ST_EVAL for
//   each candidate day and ST_FETCH and ST_MATCH for each table entry
//   visited, then ST_MUL, ST_SUM and ST_FIN; a table write gives no response.
// One query is in the walk at a time, bounded by the 22-step day divider and
//   the single read port of the holiday table.
// Reset: synchronous rst restores the configuration registers to defaults
//   and clears the control; the holiday table holds nothing valid until written.
// ----------------------------------------------------------------------------
`include "next_session_start_finder_unit_macros.svh"

module next_session_start_finder_unit #(
  parameter int HOLIDAYS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [nssf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nssf_pkg::CFG_DATA_W-1:0]     cfg_data,
  nssf_req_if.sink                            req,
  nssf_rsp_if.source                          rsp
);
  import nssf_pkg::*;

  localparam int AW = (HOLIDAYS > 1) ? $clog2(HOLIDAYS) : 1;
  localparam int CW = $clog2(HOLIDAYS + 1);
  localparam logic [8:0] HOL_LIM = 9'(HOLIDAYS);

  // configuration registers
  logic signed [17:0] zone;
  logic [16:0]        open_t;
  logic [5:0]         hcount;
  logic signed [31:0] cov;

  // walk state
  walk_state_t          state;
  walk_state_t          state_next;
  logic signed [DW-1:0] day;
  wday_t                wday;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        nlim;
  logic                 hmode;
  logic                 insuff;
  logic signed [PROD_W-1:0] prod;
  logic signed [OUT_W-1:0]  result;

  // response register
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_start;
  logic                    out_insuff;

  // decode
  logic                 accept;
  logic                 is_query;
  logic                 div_start;
  logic [8:0]           hcount_ext;
  logic [8:0]           hol_eff;
  logic [8:0]           widx_ext;
  logic                 mem_we;
  logic                 mem_rd;
  logic signed [31:0]   mem_rdata;
  logic signed [DW-1:0] hol_day;
  logic                 cov_fail;
  logic                 weekend;
  logic                 scan_more;
  logic                 out_free;
  logic signed [PROD_W-1:0] open_ext;
  logic signed [PROD_W-1:0] zone_ext;
  logic signed [PROD_W-1:0] sum_full;
  div_res_t             div_res;

  assign accept     = req.valid && req.ready;
  assign is_query   = (req.mode == MODE_PLAIN) || (req.mode == MODE_HOLIDAY);
  assign hcount_ext = 9'(hcount);
  // a count beyond the table saturates to its depth
  assign hol_eff    = (hcount_ext > HOL_LIM) ? HOL_LIM : hcount_ext;
  assign widx_ext   = 9'(req.entry_index);
  assign hol_day    = DW'(mem_rdata);
  assign cov_fail   = hmode && (day > DW'(cov));
  assign weekend    = (wday >= WD_SAT);
  assign scan_more  = hmode && (ptr < nlim);
  assign out_free   = !out_valid || rsp.ready;
  assign open_ext   = PROD_W'(signed'({1'b0, open_t}));
  assign zone_ext   = PROD_W'(zone);
  assign sum_full   = prod + open_ext - zone_ext;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      zone   <= 18'sd32400;
      open_t <= 17'd32400;
      hcount <= 6'd0;
      cov    <= 32'sh7FFF_FFFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ZONE_OFFSET: zone   <= signed'(cfg_data[17:0]);
        REG_OPEN_TIME:   open_t <= cfg_data[16:0];
        REG_HOL_COUNT:   hcount <= cfg_data[5:0];
        REG_COVERAGE:    cov    <= signed'(cfg_data);
      endcase
    end
  end

  nssf_daydiv u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .from_time (req.from_time),
    .zone      (zone),
    .res       (div_res)
  );

  nssf_holtab #(
    .DEPTH (HOLIDAYS),
    .AW    (AW)
  ) u_tab (
    .clk   (clk),
    .we    (mem_we),
    .waddr (widx_ext[AW-1:0]),
    .wdata (req.entry_day),
    .rd    (mem_rd),
    .raddr (ptr[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Day walk. The table pointer only moves forward: for a rising candidate
  // day the first entry not below it never moves back, so each entry is read at
  // most twice per query, the second time only after it matched. A day is a holiday when that entry equals it.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (cov_fail) begin
          state_next = ST_FIN;
        end else if (weekend) begin
          state_next = ST_EVAL;
        end else if (scan_more) begin
          state_next = ST_FETCH;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_FETCH: state_next = ST_MATCH;
      ST_MATCH: begin
        if (hol_day > day) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    div_start = accept && is_query;
    mem_we    = accept && (req.mode == MODE_WRITE) && (widx_ext < HOL_LIM);
    mem_rd    = (state == ST_FETCH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          hmode  <= (req.mode == MODE_HOLIDAY);
          ptr    <= '0;
          nlim   <= hol_eff[CW-1:0];
          insuff <= 1'b0;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          day  <= div_res.day;
          wday <= div_res.wday;
        end
      end
      ST_EVAL: begin
        if (cov_fail) begin
          result <= '0;
          insuff <= 1'b1;
        end else if (weekend) begin
          day  <= day + DW'(1);
          wday <= wday_next(wday);
        end
      end
      ST_MATCH: begin
        if (hol_day < day) begin
          ptr <= ptr + CW'(1);
        end else if (hol_day == day) begin
          day  <= day + DW'(1);
          wday <= wday_next(wday);
        end
      end
      ST_MUL:   prod   <= PROD_W'(day) * DAY_SECONDS;
      ST_SUM:   result <= sum_full[OUT_W-1:0];
      ST_FETCH, ST_FIN: begin
      end
    endcase
  end

  // response register, kept apart from the walk so a new request can enter
  // while a response waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_start  <= result;
      out_insuff <= insuff;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.session_start = out_start;
  assign rsp.insufficient  = out_insuff;

  `NSSF_ASSERT_NOW(a_rd_wr_apart, mem_rd, !mem_we, "table read and write overlap")
  `NSSF_ASSERT_NOW(a_ptr_range, state != ST_IDLE && state != ST_DIV, ptr <= nlim,
                   "table pointer past count")
  `NSSF_ASSERT_NOW(a_insuff_zero, rsp.valid && rsp.insufficient, rsp.session_start == '0,
                   "insufficient response with nonzero time")
  `NSSF_ASSERT_NEXT(a_holiday_step, state == ST_MATCH && hol_day == day,
                    day == $past(day) + DW'(1), "holiday not skipped")

endmodule

@@ bench/next_session_start_finder_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_open_checker
// Watches the request, response and register ports of the next session start
// finder, works out each expected opening time and compares the responses.
// ----------------------------------------------------------------------------
module session_open_checker
  import nssf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  nssf_req_if                   req,
  nssf_rsp_if                   rsp,
  output int                    mismatches,
  output int                    awaiting
);

  localparam int     HOLIDAY_SLOTS = 32;
  localparam longint SECS_PER_DAY  = 86400;

  typedef struct packed {
    logic signed [48:0] session_start;
    logic               insufficient;
  } opening_t;

  longint   zone_ofs;
  longint   open_tod;
  longint   cover_day;
  logic [5:0] cal_count;
  longint   calendar [HOLIDAY_SLOTS];
  opening_t due_openings [$];
  opening_t due;
  int       fail_count;

  function automatic bit weekend(input longint d);
    longint wd;
    wd = ((d + 3) % 7 + 7) % 7;
    return wd >= longint'(WD_SAT);
  endfunction

  // scan stops at the first entry later than the day
  function automatic bit on_calendar(input longint d);
    int n;
    n = (cal_count > HOLIDAY_SLOTS) ? HOLIDAY_SLOTS : int'(cal_count);
    for (int i = 0; i < n; i++) begin
      if (calendar[i] == d) return 1'b1;
      if (calendar[i] > d) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic opening_t next_opening(input mode_t m, input logic signed [47:0] t);
    opening_t o;
    longint   shifted;
    longint   d;
    longint   opening;
    shifted = longint'(t) + zone_ofs;
    d = shifted / SECS_PER_DAY;
    if ((shifted % SECS_PER_DAY) != 0 && shifted < 0) d = d - 1;
    d = d + 1;
    o.insufficient  = 1'b1;
    o.session_start = '0;
    if (m == MODE_PLAIN) begin
      while (weekend(d)) d = d + 1;
    end else begin
      while (weekend(d) || on_calendar(d)) begin
        if (d > cover_day) return o;
        d = d + 1;
      end
      if (d > cover_day) return o;
    end
    opening = d * SECS_PER_DAY + open_tod - zone_ofs;
    o.insufficient  = 1'b0;
    o.session_start = opening[48:0];
    return o;
  endfunction

  initial begin
    mismatches = 0;
    awaiting   = 0;
    fail_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      zone_ofs  = 32400;
      open_tod  = 32400;
      cal_count = '0;
      cover_day = 2147483647;
      foreach (calendar[i]) calendar[i] = 0;
      due_openings.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ZONE_OFFSET: zone_ofs  = $signed(cfg_data[17:0]);
          REG_OPEN_TIME:   open_tod  = cfg_data[16:0];
          REG_HOL_COUNT:   cal_count = cfg_data[5:0];
          REG_COVERAGE:    cover_day = $signed(cfg_data);
          default: ;
        endcase
      end

      if (rsp.valid && rsp.ready) begin
        if (due_openings.size() == 0) begin
          fail_count++;
          $display("%0t: response with none expected: session_start %0d insufficient %0b",
                   $time, rsp.session_start, rsp.insufficient);
        end else begin
          due = due_openings.pop_front();
          if (rsp.session_start !== due.session_start) begin
            fail_count++;
            $display("%0t: session_start expected %0d, got %0d",
                     $time, due.session_start, rsp.session_start);
          end
          if (rsp.insufficient !== due.insufficient) begin
            fail_count++;
            $display("%0t: insufficient expected %0b, got %0b",
                     $time, due.insufficient, rsp.insufficient);
          end
        end
      end

      if (req.valid && req.ready) begin
        case (req.mode)
          MODE_WRITE:                calendar[req.entry_index] = req.entry_day;
          MODE_PLAIN, MODE_HOLIDAY: due_openings.push_back(next_opening(req.mode, req.from_time));
          default: ;
        endcase
      end
    end
    mismatches <= fail_count;
    awaiting   <= due_openings.size();
  end

endmodule

@@ bench/next_session_start_finder_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_session_start_finder_unit_tb
// Drives plain, holiday-aware, table-write and unused requests into the
// finder under a range of register settings, with bursty requests and an
// irregular response stall; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module next_session_start_finder_unit_tb;
  import nssf_pkg::*;

  localparam mode_t  MODE_IGNORED    = 2'd3;   // unused mode, block drops it
  localparam int     HOLIDAY_SLOTS   = 32;
  localparam longint SECS_PER_DAY    = 86400;
  localparam int     PHASES          = 10;
  localparam int     ITEMS_PER_PHASE = 80;
  localparam int     LONG_HOLD       = 400;    // cycles of blocked responses
  localparam int     WATCHDOG_LIMIT  = 20000;  // quiet cycles before giving up

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  nssf_req_if req_ch ();
  nssf_rsp_if rsp_ch ();

  int     mismatches;
  int     awaiting;
  int     long_holds_asked;
  int     quiet_cycles;
  int     burst_left;
  bit     steady;      // no gaps between requests in this phase
  bit     offering;    // valid currently held high
  longint cur_zone;    // zone offset as the block sees it
  longint cal_base;    // first day of the current calendar load

  next_session_start_finder_unit #(.HOLIDAYS(HOLIDAY_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  session_open_checker opening_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run that stops moving requests and responses is a failure.
  // --------------------------------------------------------------------------
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Response side. Switches between stall styles every so often; when the
  // request side asks, it blocks responses outright so the block backs up and
  // has to refuse further requests.
  // --------------------------------------------------------------------------
  initial begin
    int style;
    int span;
    int held;
    style = 0;
    span  = 0;
    held  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (held != long_holds_asked) begin
        held = long_holds_asked;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span  = $urandom_range(20, 200);
        end
        span--;
        case (style)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 9) >= 3);
          2:       rsp_ch.ready <= (span % 3 == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 9) >= 7);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side helpers. Every task is entered just after a rising edge.
  // --------------------------------------------------------------------------

  // UTC seconds for a given second of a local day
  function automatic logic signed [47:0] utc_at(input longint d, input longint sec);
    logic [63:0] v;
    v = d * SECS_PER_DAY + sec - cur_zone;
    return v[47:0];
  endfunction

  // burst/gap pacing after each accepted request
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else if (!steady) begin
      req_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic offer(input mode_t m, input logic [47:0] t, input logic [4:0] slot,
                       input logic [31:0] entry);
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= m;
    req_ch.from_time   <= t;
    req_ch.entry_index <= slot;
    req_ch.entry_day   <= entry;
    offering = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    pace();
  endtask

  // stop offering and wait for every outstanding response, then let a
  // trailing table write or dropped request work its way through
  task automatic settle();
    if (offering) begin
      req_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // block must be idle; all four registers in consecutive cycles
  task automatic program_registers(input logic [31:0] zone_raw, input logic [31:0] open_raw,
                                   input logic [31:0] count_raw, input logic [31:0] cover_raw);
    cfg_write <= 1'b1;
    cfg_index <= REG_ZONE_OFFSET;
    cfg_data  <= zone_raw;
    @(posedge clk);
    cfg_index <= REG_OPEN_TIME;
    cfg_data  <= open_raw;
    @(posedge clk);
    cfg_index <= REG_HOL_COUNT;
    cfg_data  <= count_raw;
    @(posedge clk);
    cfg_index <= REG_COVERAGE;
    cfg_data  <= cover_raw;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_zone = $signed(zone_raw[17:0]);
  endtask

  // sorted calendar: mostly runs of consecutive days, a few jumps
  task automatic load_calendar(input longint first_day);
    longint d;
    int     s;
    logic [63:0] raw;
    cal_base = first_day;
    d = first_day;
    for (s = 0; s < HOLIDAY_SLOTS; s++) begin
      raw = {$urandom(), $urandom()};
      d = d + (($urandom_range(0, 3) == 0) ? longint'($urandom_range(2, 5)) : 1);
      offer(MODE_WRITE, raw[47:0], 5'(s), 32'(d));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    longint      day;
    logic [63:0] raw;
    logic [31:0] entry;
    logic [31:0] zone_raw;
    logic [31:0] open_raw;
    logic [31:0] count_raw;
    logic [31:0] cover_raw;
    int          pick;
    int          p;
    int          k;

    rst                <= 1'b1;
    cfg_write          <= 1'b0;
    cfg_index          <= REG_ZONE_OFFSET;
    cfg_data           <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= MODE_PLAIN;
    req_ch.from_time   <= '0;
    req_ch.entry_index <= '0;
    req_ch.entry_day   <= '0;
    long_holds_asked   <= 0;
    offering   = 1'b0;
    steady     = 1'b0;
    burst_left = 0;
    cur_zone   = 32400;
    cal_base   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // ---- directed: reset settings, plain queries ----
    // epoch day 0 is a Thursday, so local day 1 is Friday, 2-3 the weekend
    offer(MODE_PLAIN, 48'h0, 5'd0, 32'd0);
    offer(MODE_PLAIN, 48'h7FFF_FFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    offer(MODE_PLAIN, 48'h8000_0000_0000, 5'd0, 32'd0);
    offer(MODE_PLAIN, 48'hFFFF_FFFF_FFFF, 5'd0, 32'd0);
    offer(MODE_PLAIN, utc_at(1, 50000), 5'd0, 32'd0);   // Friday: skip the weekend
    offer(MODE_PLAIN, utc_at(2, 0), 5'd0, 32'd0);       // first second of Saturday
    offer(MODE_PLAIN, utc_at(3, 86399), 5'd0, 32'd0);   // last second of Sunday
    offer(MODE_PLAIN, utc_at(-10, 12345), 5'd0, 32'd0); // before the epoch
    offer(MODE_IGNORED, 48'h0, 5'd31, 32'hFFFF_FFFF);   // dropped, no response
    offer(MODE_HOLIDAY, utc_at(1, 100), 5'd0, 32'd0);   // empty calendar, nothing read

    // small calendar Mon-Wed of the next week plus the Monday after
    offer(MODE_WRITE, 48'h0, 5'd0, 32'd4);
    offer(MODE_WRITE, 48'h0, 5'd1, 32'd5);
    offer(MODE_WRITE, 48'h0, 5'd2, 32'd6);
    offer(MODE_WRITE, 48'h0, 5'd3, 32'd11);
    offer(MODE_WRITE, 48'h0, 5'd31, 32'h8000_0000);     // outside the count, never read
    offer(MODE_WRITE, 48'h0, 5'd30, 32'h7FFF_FFFF);
    settle();
    program_registers(32'd32400, 32'd0, 32'd4, 32'd20);

    offer(MODE_HOLIDAY, utc_at(1, 7), 5'd0, 32'd0);      // weekend then three holidays
    offer(MODE_HOLIDAY, utc_at(10, 500), 5'd0, 32'd0);   // single holiday
    offer(MODE_PLAIN, utc_at(3, 0), 5'd0, 32'd0);        // plain ignores the calendar
    offer(MODE_HOLIDAY, utc_at(19, 0), 5'd0, 32'd0);     // chosen day is the last covered
    offer(MODE_HOLIDAY, utc_at(20, 86399), 5'd0, 32'd0); // chosen day past coverage
    offer(MODE_HOLIDAY, utc_at(22, 5), 5'd0, 32'd0);     // skipped day past coverage
    offer(MODE_HOLIDAY, utc_at(-5, 3), 5'd0, 32'd0);     // before every entry
    settle();

    // every slot written from here on, so any count is safe
    load_calendar(longint'($urandom_range(0, 30000)));

    // ---- random phases, each with its own register setting ----
    for (p = 0; p < PHASES; p++) begin
      settle();

      case (p % 5)
        0:       zone_raw = 32'hFFFE_AE80;                              // -86400
        1:       zone_raw = 32'd86400;
        2:       zone_raw = 32'd0;
        3:       zone_raw = $urandom();                                 // any 18-bit value
        default: zone_raw = {14'($urandom_range(0, 16383)), 18'd32400}; // junk above
      endcase
      case (p % 4)
        0:       open_raw = 32'd0;
        1:       open_raw = 32'd86399;
        2:       open_raw = $urandom();
        default: open_raw = $urandom_range(0, 86399);
      endcase
      case (p % 5)
        0:       count_raw = 32'd32;
        1:       count_raw = 32'd63;                 // saturates to the table size
        2:       count_raw = $urandom_range(0, 32);
        3:       count_raw = 32'd0;
        default: count_raw = $urandom_range(33, 63);
      endcase

      // new calendar on most phases, far from the epoch on some
      day = (p % 3 == 0) ? longint'($urandom_range(0, 30000))
                         : longint'($urandom_range(0, 32'd3000000000)) - 64'sd1500000000;
      case ((p + 1) % 4)
        0:       cover_raw = 32'h7FFF_FFFF;
        1:       cover_raw = 32'h8000_0000;
        2:       cover_raw = 32'(((p % 3 == 2) ? cal_base : day) +
                                 longint'($urandom_range(0, 160)));
        default: cover_raw = $urandom();
      endcase
      program_registers(zone_raw, open_raw, count_raw, cover_raw);

      // back-to-back requests; twice also block responses for a long while
      steady = (p % 4 == 1);
      if (p == 1 || p == 5) long_holds_asked <= long_holds_asked + 1;

      if (p % 3 != 2) load_calendar(day);

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        raw  = {$urandom(), $urandom()};
        day  = cal_base + longint'($urandom_range(0, 160)) - 6;
        if (pick < 45) begin
          offer(MODE_HOLIDAY, utc_at(day, $urandom_range(0, 86399)), raw[52:48], raw[63:32]);
        end else if (pick < 62) begin
          offer(MODE_PLAIN, utc_at(day, $urandom_range(0, 86399)), raw[52:48], raw[63:32]);
        end else if (pick < 72) begin
          // anywhere in the 48-bit range
          offer(raw[53] ? MODE_HOLIDAY : MODE_PLAIN, raw[47:0], raw[52:48], raw[63:32]);
        end else if (pick < 86) begin
          // table edits: near the calendar, or any day at all (leaves it unsorted)
          entry = (pick < 82) ? 32'(cal_base + longint'($urandom_range(0, 160)))
                              : raw[63:32];
          offer(MODE_WRITE, raw[47:0], raw[52:48], entry);
        end else if (pick < 92) begin
          offer(MODE_IGNORED, raw[47:0], raw[52:48], raw[63:32]);
        end else begin
          // first or last second of a local day
          offer(MODE_HOLIDAY, utc_at(day, raw[54] ? 86399 : 0), raw[52:48], raw[63:32]);
        end
      end
      steady = 1'b0;
    end

    settle();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
